FILE: rtl/pd_line_follower_steering_macros.svh
// assertion macros used by the checker file
`ifndef PD_LINE_FOLLOWER_STEERING_MACROS_SVH
`define PD_LINE_FOLLOWER_STEERING_MACROS_SVH

// same-cycle implication, disabled during reset
`define PDLS_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("pdls assertion failed");

// next-cycle implication, disabled during reset
`define PDLS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("pdls assertion failed");

`endif

FILE: rtl/pdls_pkg.sv
// shared types and constants of the pd line follower steering block
package pdls_pkg;

  localparam int SPEED_W        = 12;
  localparam int GAIN_W         = 12;
  localparam int ERR_W          = 4;
  localparam int STAMP_W        = 32;
  localparam int CFG_IDX_W      = 3;
  localparam int TIME_WIDTH_DEF = 32;
  localparam int FRAC_BITS_DEF  = 16;

  // register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PROP_GAIN     = 3'd0,
    REG_DERIV_GAIN    = 3'd1,
    REG_BASE_LEFT     = 3'd2,
    REG_BASE_RIGHT    = 3'd3,
    REG_SPEED_FLOOR   = 3'd4,
    REG_SPEED_CEILING = 3'd5,
    REG_BLACK_LEVEL   = 3'd6
  } reg_idx_t;

  // operation codes
  localparam logic OP_STEP  = 1'b0;
  localparam logic OP_CLEAR = 1'b1;

  // line error codes
  localparam logic signed [ERR_W-1:0] ERR_CENTER   = 4'sd0;
  localparam logic signed [ERR_W-1:0] ERR_LEFT     = 4'sd1;
  localparam logic signed [ERR_W-1:0] ERR_RIGHT    = -4'sd1;
  localparam logic signed [ERR_W-1:0] ERR_LOST_POS = 4'sd5;
  localparam logic signed [ERR_W-1:0] ERR_LOST_NEG = -4'sd5;

  typedef struct packed {
    logic               operation;
    logic               left_sensor;
    logic               right_sensor;
    logic [STAMP_W-1:0] now_us;
  } cmd_t;

  typedef struct packed {
    logic [SPEED_W-1:0]      left_speed;
    logic [SPEED_W-1:0]      right_speed;
    logic signed [ERR_W-1:0] line_error;
  } res_t;

endpackage

FILE: rtl/pdls_div.sv
// restoring divider, one quotient bit per cycle
module pdls_div #(
  parameter int NUM_W = 20,
  parameter int DEN_W = 32
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic             done,
  output logic [NUM_W-1:0] quot
);
  localparam int CNT_W = $clog2(NUM_W + 1);

  logic             busy;
  logic [CNT_W-1:0] cnt;
  logic [DEN_W-1:0] rem;
  logic [DEN_W-1:0] den_q;
  logic [NUM_W-1:0] num_sh;
  logic [DEN_W:0]   trial;
  logic [DEN_W:0]   trial_sub;
  logic             fits;

  // shared compare and subtract
  assign trial     = {rem, num_sh[NUM_W-1]};
  assign trial_sub = trial - {1'b0, den_q};
  assign fits      = trial >= {1'b0, den_q};

  // iteration control and datapath
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy   <= 1'b1;
        cnt    <= CNT_W'(NUM_W);
        rem    <= '0;
        den_q  <= den;
        num_sh <= num;
      end else if (busy) begin
        rem    <= fits ? trial_sub[DEN_W-1:0] : trial[DEN_W-1:0];
        quot   <= {quot[NUM_W-2:0], fits};
        num_sh <= {num_sh[NUM_W-2:0], 1'b0};
        cnt    <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule

FILE: rtl/pdls_clamp.sv
// truncate a fixed-point speed toward zero and clamp it
module pdls_clamp #(
  parameter int FRAC_BITS = 16
) (
  input  logic signed [FRAC_BITS+17:0]  sum,
  input  logic [pdls_pkg::SPEED_W-1:0]  floor_lim,
  input  logic [pdls_pkg::SPEED_W-1:0]  ceil_lim,
  output logic [pdls_pkg::SPEED_W-1:0]  speed
);
  import pdls_pkg::*;

  localparam int SUM_W = FRAC_BITS + 18;
  localparam int INT_W = SUM_W - FRAC_BITS;

  logic [SUM_W-1:0]        mag;
  logic [INT_W-1:0]        int_mag;
  logic signed [INT_W-1:0] int_val;
  logic signed [INT_W-1:0] floor_s;
  logic signed [INT_W-1:0] ceil_s;

  // magnitude shift gives truncation toward zero
  always_comb begin
    mag     = sum[SUM_W-1] ? SUM_W'(-sum) : SUM_W'(sum);
    int_mag = INT_W'(mag >> FRAC_BITS);
    int_val = sum[SUM_W-1] ? $signed(-int_mag) : $signed(int_mag);
    floor_s = $signed({{(INT_W-SPEED_W){1'b0}}, floor_lim});
    ceil_s  = $signed({{(INT_W-SPEED_W){1'b0}}, ceil_lim});
  end

  // floor is tested before ceiling
  always_comb begin
    if (int_val < floor_s) begin
      speed = floor_lim;
    end else if (int_val > ceil_s) begin
      speed = ceil_lim;
    end else begin
      speed = int_val[SPEED_W-1:0];
    end
  end
endmodule

FILE: rtl/pd_line_follower_steering.sv
// pd line follower steering: top level with sequencer and shared multiplier
// sequence after a step cmd transfer: S_DIV when the error changes (the divider makes one
// quotient bit per cycle), then S_MULP, S_MULD, S_LEFT, S_RIGHT; a clear runs S_LEFT, S_RIGHT
// one cmd at a time: cmd stalls until the result is registered
// reset: synchronous, clears history, sequencer and result valid; gains reload defaults
module pd_line_follower_steering #(
  parameter int TIME_WIDTH = pdls_pkg::TIME_WIDTH_DEF,
  parameter int FRAC_BITS  = pdls_pkg::FRAC_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cmd_valid,
  output logic                            cmd_stall,
  input  pdls_pkg::cmd_t                  cmd,
  output logic                            res_valid,
  input  logic                            res_stall,
  output pdls_pkg::res_t                  res,
  input  logic                            cfg_write,
  input  logic [pdls_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [pdls_pkg::GAIN_W-1:0]     cfg_data
);
  import pdls_pkg::*;

  localparam int NUM_W = FRAC_BITS + 4;
  localparam int DRV_W = NUM_W + 1;
  localparam int SUM_W = FRAC_BITS + 18;

  typedef enum logic [2:0] {
    S_IDLE, S_DIV, S_MULP, S_MULD, S_LEFT, S_RIGHT
  } state_t;

  state_t state;

  // configuration
  logic [GAIN_W-1:0]  prop_gain;
  logic [GAIN_W-1:0]  deriv_gain;
  logic [SPEED_W-1:0] base_left;
  logic [SPEED_W-1:0] base_right;
  logic [SPEED_W-1:0] speed_floor;
  logic [SPEED_W-1:0] speed_ceiling;
  logic               black_level;

  // history and working registers
  logic signed [ERR_W-1:0] prev_error;
  logic [TIME_WIDTH-1:0]   prev_time;
  logic signed [ERR_W-1:0] err;
  logic                    diff_neg;
  logic signed [DRV_W-1:0] deriv;
  logic signed [SUM_W-1:0] acc;
  logic [SPEED_W-1:0]      left_q;

  logic                    cmd_acc;
  logic                    lb;
  logic                    rb;
  logic signed [ERR_W-1:0] err_new;
  logic signed [ERR_W:0]   diff;
  logic [ERR_W-1:0]        diff_mag;
  logic [TIME_WIDTH-1:0]   now_t;
  logic [TIME_WIDTH-1:0]   dt;
  logic [TIME_WIDTH-1:0]   den;
  logic [NUM_W-1:0]        num;
  logic                    div_start;
  logic                    div_done;
  logic [NUM_W-1:0]        quot;

  logic signed [DRV_W-1:0] mul_a;
  logic [GAIN_W-1:0]       mul_b;
  logic signed [SUM_W-1:0] prod;
  logic [SPEED_W-1:0]      base_sel;
  logic signed [SUM_W-1:0] base_q;
  logic signed [SUM_W-1:0] sum;
  logic [SPEED_W-1:0]      speed;

  assign cmd_stall = rst || (state != S_IDLE);
  assign cmd_acc   = cmd_valid && !cmd_stall;

  // line error from the sensor pair
  always_comb begin
    lb = (cmd.left_sensor == black_level);
    rb = (cmd.right_sensor == black_level);
    if (lb && rb) begin
      err_new = ERR_CENTER;
    end else if (lb) begin
      err_new = ERR_LEFT;
    end else if (rb) begin
      err_new = ERR_RIGHT;
    end else begin
      err_new = (prev_error > ERR_CENTER) ? ERR_LOST_POS : ERR_LOST_NEG;
    end
  end

  // divider operands: error change over time gap
  always_comb begin
    diff     = {err_new[ERR_W-1], err_new} - {prev_error[ERR_W-1], prev_error};
    diff_mag = diff[ERR_W] ? ERR_W'(-diff) : ERR_W'(diff);
    now_t    = TIME_WIDTH'(cmd.now_us);
    dt       = now_t - prev_time;
    den      = (dt == '0) ? TIME_WIDTH'(1) : dt;
    num      = {diff_mag, {FRAC_BITS{1'b0}}};
  end

  assign div_start = cmd_acc && (cmd.operation == OP_STEP) && (err_new != prev_error);

  pdls_div #(
    .NUM_W(NUM_W),
    .DEN_W(TIME_WIDTH)
  ) u_div (
    .clk  (clk),
    .rst  (rst),
    .start(div_start),
    .num  (num),
    .den  (den),
    .done (div_done),
    .quot (quot)
  );

  // shared multiplier: proportional then derivative term
  always_comb begin
    if (state == S_MULP) begin
      mul_a = {{(DRV_W-ERR_W){err[ERR_W-1]}}, err};
      mul_b = prop_gain;
    end else begin
      mul_a = deriv;
      mul_b = deriv_gain;
    end
    prod = mul_a * $signed({1'b0, mul_b});
  end

  // shared steering adder, left then right
  always_comb begin
    base_sel = (state == S_LEFT) ? base_left : base_right;
    base_q   = $signed(SUM_W'({base_sel, {FRAC_BITS{1'b0}}}));
    sum      = (state == S_LEFT) ? base_q - acc : base_q + acc;
  end

  pdls_clamp #(
    .FRAC_BITS(FRAC_BITS)
  ) u_clamp (
    .sum      (sum),
    .floor_lim(speed_floor),
    .ceil_lim (speed_ceiling),
    .speed    (speed)
  );

  // sequencer, configuration and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      res_valid     <= 1'b0;
      prev_error    <= ERR_CENTER;
      prev_time     <= '0;
      prop_gain     <= '0;
      deriv_gain    <= '0;
      base_left     <= '0;
      base_right    <= '0;
      speed_floor   <= '0;
      speed_ceiling <= {SPEED_W{1'b1}};
      black_level   <= 1'b1;
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          REG_PROP_GAIN:     prop_gain     <= cfg_data;
          REG_DERIV_GAIN:    deriv_gain    <= cfg_data;
          REG_BASE_LEFT:     base_left     <= cfg_data;
          REG_BASE_RIGHT:    base_right    <= cfg_data;
          REG_SPEED_FLOOR:   speed_floor   <= cfg_data;
          REG_SPEED_CEILING: speed_ceiling <= cfg_data;
          REG_BLACK_LEVEL:   black_level   <= cfg_data[0];
          default: ;
        endcase
      end

      // result transfer frees the output register unless a new result lands
      if (res_valid && !res_stall && (state != S_RIGHT)) begin
        res_valid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (cmd_acc) begin
            if (cmd.operation == OP_CLEAR) begin
              prev_error <= ERR_CENTER;
              err        <= ERR_CENTER;
              acc        <= '0;
              state      <= S_LEFT;
            end else begin
              err        <= err_new;
              prev_error <= err_new;
              prev_time  <= now_t;
              diff_neg   <= diff[ERR_W];
              deriv      <= '0;
              state      <= div_start ? S_DIV : S_MULP;
            end
          end
        end
        S_DIV: begin
          if (div_done) begin
            deriv <= diff_neg ? -$signed({1'b0, quot}) : $signed({1'b0, quot});
            state <= S_MULP;
          end
        end
        S_MULP: begin
          acc   <= prod <<< FRAC_BITS;
          state <= S_MULD;
        end
        S_MULD: begin
          acc   <= acc + prod;
          state <= S_LEFT;
        end
        S_LEFT: begin
          left_q <= speed;
          state  <= S_RIGHT;
        end
        S_RIGHT: begin
          if (!res_valid || !res_stall) begin
            res.left_speed  <= left_q;
            res.right_speed <= speed;
            res.line_error  <= err;
            res_valid       <= 1'b1;
            state           <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

FILE: rtl/pdls_check.sv
// port-level checker for the steering block and its bind
`include "pd_line_follower_steering_macros.svh"

module pdls_check (
  input logic           clk,
  input logic           rst,
  input logic           cmd_valid,
  input logic           cmd_stall,
  input logic           res_valid,
  input logic           res_stall,
  input pdls_pkg::res_t res
);
  import pdls_pkg::*;

  // a stalled result stays valid and unchanged
  `PDLS_ASSERT_NEXT(a_res_hold, res_valid && res_stall, res_valid)
  `PDLS_ASSERT_NEXT(a_res_stable, res_valid && res_stall, $stable(res))

  // the block is busy right after every cmd transfer
  `PDLS_ASSERT_NEXT(a_busy_after_cmd, cmd_valid && !cmd_stall, cmd_stall)

  // only the five error codes ever leave the block
  `PDLS_ASSERT_NOW(a_err_code, res_valid, (res.line_error == ERR_CENTER) || (res.line_error == ERR_LEFT) || (res.line_error == ERR_RIGHT) || (res.line_error == ERR_LOST_POS) || (res.line_error == ERR_LOST_NEG))
endmodule

bind pd_line_follower_steering pdls_check u_pdls_check (.*);
